/* hw/rtl/slas_pkg.sv */
// Shared types and constants for the scanout line address sequencer.
package slas_pkg;

    localparam int unsigned DIM_W        = 11;
    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned WORDS_W      = 10;
    localparam int unsigned PROD_W       = 2 * DIM_W;
    localparam int unsigned STEP_W       = 4;
    localparam int unsigned CFG_INDEX_W  = 3;
    localparam int unsigned CFG_DATA_W   = 32;
    localparam int unsigned CHANNEL_COUNT = 2;

    localparam logic [DIM_W-1:0] RESET_ACTIVE_LINES  = 11'd480;
    localparam logic [DIM_W-1:0] RESET_ACTIVE_PIXELS = 11'd640;
    localparam logic [DIM_W-1:0] RESET_LINE_WIDTH    = 11'd640;
    localparam logic [DIM_W-1:0] RESET_REPEAT        = 11'd1;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_LINES  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_PIXELS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_BUFFER = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_ZERO   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUFFER_ONE    = 3'd4;

    typedef enum logic [1:0] {
        KIND_LINE_DONE    = 2'd0,
        KIND_FRAME_READY  = 2'd1,
        KIND_MODE_REQUEST = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_MODE,
        ST_DIV_LINE,
        ST_MUL,
        ST_DIV_PIX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] num;
        logic [DIM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] a;
        logic [DIM_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } mul_rsp_t;

endpackage

/* hw/rtl/slas_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module slas_div (
    input  logic              clk,
    input  logic              rst_n,
    input  slas_pkg::div_req_t req,
    output slas_pkg::div_rsp_t rsp
);

    logic [slas_pkg::DIM_W-1:0]  rem_reg, rem_next;
    logic [slas_pkg::DIM_W-1:0]  quo_reg, quo_next;
    logic [slas_pkg::DIM_W-1:0]  den_reg, den_next;
    logic [slas_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [slas_pkg::DIM_W:0]    rem_sh;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, quo_reg[slas_pkg::DIM_W-1]};
        if (req.start)
        begin
            rem_next = '0;
            quo_next = req.num;
            den_next = req.den;
            cnt_next = slas_pkg::STEP_W'(slas_pkg::DIM_W);
        end
        else if (cnt_reg != '0)
        begin
            // shift in next dividend bit, subtract when it fits
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = slas_pkg::DIM_W'(rem_sh - {1'b0, den_reg});
                quo_next = {quo_reg[slas_pkg::DIM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[slas_pkg::DIM_W-1:0];
                quo_next = {quo_reg[slas_pkg::DIM_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == slas_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* hw/rtl/slas_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module slas_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  slas_pkg::mul_req_t req,
    output slas_pkg::mul_rsp_t rsp
);

    logic [slas_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [slas_pkg::PROD_W-1:0] mcand_reg, mcand_next;
    logic [slas_pkg::DIM_W-1:0]  mplier_reg, mplier_next;
    logic [slas_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            acc_next    = '0;
            mcand_next  = slas_pkg::PROD_W'(req.a);
            mplier_next = req.b;
            cnt_next    = slas_pkg::STEP_W'(slas_pkg::DIM_W);
        end
        else if (cnt_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[slas_pkg::PROD_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[slas_pkg::DIM_W-1:1]};
            cnt_next    = cnt_reg - 1'b1;
            done_next   = (cnt_reg == slas_pkg::STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

/* hw/rtl/scanout_line_address_sequencer.sv */
// Scanout line address sequencer top level: event intake, frame/mode state and result register.
//
// Each transfer in (line_done, frame_ready, mode_request or an unknown kind) gives exactly
// one result transfer out; only line_done produces non-zero fields. One event is in flight
// at a time. The result passes through ST_DONE into the output register: straight from
// intake for frame_ready and unknown kinds, after one pass of the 11-step serial divider
// (lines/height) for mode_request, after the divider (scanline/repeat) and then the
// 11-step serial multiplier (line*width) for line_done, and on a resume line after a
// further divider pass for the pixel repeat. The event channel reopens at the edge that
// loads the output register. The divider and multiplier retire one bit per cycle. A
// finished result waits in the output register, so the next event can be taken while the
// previous result is still stalled; a new result that finds the output register still
// stalled waits, and the event channel with it, until that transfer completes.
// Configuration is a plain write port; write only while no event is in flight.
module scanout_line_address_sequencer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration
    input  logic                                  cfg_we,
    input  logic [slas_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [slas_pkg::CFG_DATA_W-1:0]       cfg_data,
    // event channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            kind,
    input  logic [slas_pkg::DIM_W-1:0]            new_width,
    input  logic [slas_pkg::DIM_W-1:0]            new_height,
    // result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [slas_pkg::ADDR_W-1:0]           line_address,
    output logic [slas_pkg::WORDS_W-1:0]          word_count,
    output logic                                  channel,
    output logic                                  hold_channel,
    output logic                                  resume,
    output logic                                  resume_channel,
    output logic [slas_pkg::DIM_W-1:0]            pixel_repeat,
    output logic                                  frame_start,
    output logic                                  render_request
);

    localparam int unsigned DW = slas_pkg::DIM_W;
    localparam int unsigned AW = slas_pkg::ADDR_W;
    localparam int unsigned WW = slas_pkg::WORDS_W;

    // Zero divisors and zero repeat quotients are both treated as one.
    function automatic logic [DW-1:0] at_least_one(input logic [DW-1:0] v);
        at_least_one = (v == '0) ? DW'(1) : v;
    endfunction

    slas_pkg::state_t state_reg, state_next;

    // configuration registers
    logic [DW-1:0] active_lines_reg, active_lines_next;
    logic [DW-1:0] active_pixels_reg, active_pixels_next;
    logic          double_buffer_reg, double_buffer_next;
    logic [AW-1:0] base_zero_reg, base_zero_next;
    logic [AW-1:0] base_one_reg, base_one_next;

    // sequencing state
    logic [DW-1:0] scanline_reg, scanline_next;
    logic          channel_index_reg, channel_index_next;
    logic          display_select_reg, display_select_next;
    logic          frame_pending_reg, frame_pending_next;
    logic          change_pending_reg, change_pending_next;
    logic [DW-1:0] line_width_reg, line_width_next;
    logic [DW-1:0] line_repeat_reg, line_repeat_next;
    logic [DW-1:0] target_width_reg, target_width_next;
    logic [DW-1:0] target_repeat_reg, target_repeat_next;
    logic [1:0]    held_channel_reg, held_channel_next;   // 0 none, else channel+1

    // result being built
    logic [AW-1:0] res_addr_reg, res_addr_next;
    logic [WW-1:0] res_words_reg, res_words_next;
    logic          res_channel_reg, res_channel_next;
    logic          res_hold_reg, res_hold_next;
    logic          res_resume_reg, res_resume_next;
    logic          res_resume_ch_reg, res_resume_ch_next;
    logic [DW-1:0] res_repeat_reg, res_repeat_next;
    logic          res_frame_reg, res_frame_next;
    logic          res_render_reg, res_render_next;

    // output register
    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] out_addr_reg, out_addr_next;
    logic [WW-1:0] out_words_reg, out_words_next;
    logic          out_channel_reg, out_channel_next;
    logic          out_hold_reg, out_hold_next;
    logic          out_resume_reg, out_resume_next;
    logic          out_resume_ch_reg, out_resume_ch_next;
    logic [DW-1:0] out_repeat_reg, out_repeat_next;
    logic          out_frame_reg, out_frame_next;
    logic          out_render_reg, out_render_next;

    slas_pkg::div_req_t div_req;
    slas_pkg::div_rsp_t div_rsp;
    slas_pkg::mul_req_t mul_req;
    slas_pkg::mul_rsp_t mul_rsp;

    logic          wrap;
    logic [DW-1:0] line_scan;
    logic [DW-1:0] lw_new;
    logic [DW-1:0] lr_new;
    logic [AW-1:0] base_sel;

    slas_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    slas_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign wrap      = (scanline_reg >= active_lines_reg);
    assign line_scan = wrap ? '0 : scanline_reg;
    // width and repeat as they stand after a frame wrap applies a pending change
    assign lw_new    = (wrap && change_pending_reg) ? target_width_reg : line_width_reg;
    assign lr_new    = (wrap && change_pending_reg) ? target_repeat_reg : line_repeat_reg;
    assign base_sel  = display_select_reg ? base_one_reg : base_zero_reg;

    always_comb
    begin
        state_next          = state_reg;
        active_lines_next   = active_lines_reg;
        active_pixels_next  = active_pixels_reg;
        double_buffer_next  = double_buffer_reg;
        base_zero_next      = base_zero_reg;
        base_one_next       = base_one_reg;
        scanline_next       = scanline_reg;
        channel_index_next  = channel_index_reg;
        display_select_next = display_select_reg;
        frame_pending_next  = frame_pending_reg;
        change_pending_next = change_pending_reg;
        line_width_next     = line_width_reg;
        line_repeat_next    = line_repeat_reg;
        target_width_next   = target_width_reg;
        target_repeat_next  = target_repeat_reg;
        held_channel_next   = held_channel_reg;
        res_addr_next       = res_addr_reg;
        res_words_next      = res_words_reg;
        res_channel_next    = res_channel_reg;
        res_hold_next       = res_hold_reg;
        res_resume_next     = res_resume_reg;
        res_resume_ch_next  = res_resume_ch_reg;
        res_repeat_next     = res_repeat_reg;
        res_frame_next      = res_frame_reg;
        res_render_next     = res_render_reg;
        out_valid_next      = out_valid_reg;
        out_addr_next       = out_addr_reg;
        out_words_next      = out_words_reg;
        out_channel_next    = out_channel_reg;
        out_hold_next       = out_hold_reg;
        out_resume_next     = out_resume_reg;
        out_resume_ch_next  = out_resume_ch_reg;
        out_repeat_next     = out_repeat_reg;
        out_frame_next      = out_frame_reg;
        out_render_next     = out_render_reg;
        div_req             = '0;
        mul_req             = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                slas_pkg::CFG_ACTIVE_LINES:  active_lines_next  = cfg_data[DW-1:0];
                slas_pkg::CFG_ACTIVE_PIXELS: active_pixels_next = cfg_data[DW-1:0];
                slas_pkg::CFG_DOUBLE_BUFFER: double_buffer_next = cfg_data[0];
                slas_pkg::CFG_BUFFER_ZERO:   base_zero_next     = cfg_data[AW-1:0];
                slas_pkg::CFG_BUFFER_ONE:    base_one_next      = cfg_data[AW-1:0];
                default:                     ;
            endcase
        end

        // output register drains on a completed transfer
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            slas_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_addr_next      = '0;
                    res_words_next     = '0;
                    res_channel_next   = 1'b0;
                    res_hold_next      = 1'b0;
                    res_resume_next    = 1'b0;
                    res_resume_ch_next = 1'b0;
                    res_repeat_next    = '0;
                    res_frame_next     = 1'b0;
                    res_render_next    = 1'b0;
                    state_next         = slas_pkg::ST_DONE;
                    case (kind)
                        slas_pkg::KIND_LINE_DONE:
                        begin
                            res_channel_next   = channel_index_reg;
                            channel_index_next =
                                (32'(channel_index_reg) + 1 == slas_pkg::CHANNEL_COUNT)
                                ? 1'b0 : ~channel_index_reg;
                            if (wrap)
                            begin
                                res_frame_next = 1'b1;
                                if (frame_pending_reg)
                                begin
                                    if (double_buffer_reg)
                                    begin
                                        display_select_next = ~display_select_reg;
                                    end
                                    frame_pending_next = 1'b0;
                                    res_render_next    = 1'b1;
                                end
                                if (change_pending_reg)
                                begin
                                    // width change: park this channel until the next line that does not wrap
                                    if (line_width_reg != target_width_reg)
                                    begin
                                        held_channel_next = {1'b0, channel_index_reg} + 2'd1;
                                        res_hold_next     = 1'b1;
                                    end
                                    line_repeat_next    = target_repeat_reg;
                                    line_width_next     = target_width_reg;
                                    change_pending_next = 1'b0;
                                end
                            end
                            else if (held_channel_reg != '0)
                            begin
                                res_resume_next    = 1'b1;
                                res_resume_ch_next = held_channel_reg[0] ^ 1'b1;
                                held_channel_next  = '0;
                            end
                            res_words_next = lw_new[DW-1:1];
                            scanline_next  = line_scan + DW'(1);
                            div_req.start  = 1'b1;
                            div_req.num    = line_scan;
                            div_req.den    = at_least_one(lr_new);
                            state_next     = slas_pkg::ST_DIV_LINE;
                        end
                        slas_pkg::KIND_FRAME_READY:
                        begin
                            if (!frame_pending_reg)
                            begin
                                if (target_width_reg != line_width_reg ||
                                    target_repeat_reg != line_repeat_reg)
                                begin
                                    change_pending_next = 1'b1;
                                end
                                frame_pending_next = 1'b1;
                            end
                        end
                        slas_pkg::KIND_MODE_REQUEST:
                        begin
                            frame_pending_next = 1'b0;
                            if (!double_buffer_reg)
                            begin
                                display_select_next = 1'b0;
                            end
                            target_width_next = new_width;
                            div_req.start     = 1'b1;
                            div_req.num       = active_lines_reg;
                            div_req.den       = at_least_one(new_height);
                            state_next        = slas_pkg::ST_DIV_MODE;
                        end
                        default:
                        begin
                            // unknown kind: all-zero result
                        end
                    endcase
                end
            end

            slas_pkg::ST_DIV_MODE:
            begin
                if (div_rsp.done)
                begin
                    target_repeat_next = at_least_one(div_rsp.quotient);
                    state_next         = slas_pkg::ST_DONE;
                end
            end

            slas_pkg::ST_DIV_LINE:
            begin
                if (div_rsp.done)
                begin
                    mul_req.start = 1'b1;
                    mul_req.a     = div_rsp.quotient;
                    mul_req.b     = line_width_reg;
                    state_next    = slas_pkg::ST_MUL;
                end
            end

            slas_pkg::ST_MUL:
            begin
                if (mul_rsp.done)
                begin
                    // byte address: two bytes per pixel
                    res_addr_next = base_sel + AW'({mul_rsp.product, 1'b0});
                    if (res_resume_reg)
                    begin
                        div_req.start = 1'b1;
                        div_req.num   = active_pixels_reg;
                        div_req.den   = at_least_one(line_width_reg);
                        state_next    = slas_pkg::ST_DIV_PIX;
                    end
                    else
                    begin
                        state_next = slas_pkg::ST_DONE;
                    end
                end
            end

            slas_pkg::ST_DIV_PIX:
            begin
                if (div_rsp.done)
                begin
                    res_repeat_next = at_least_one(div_rsp.quotient);
                    state_next      = slas_pkg::ST_DONE;
                end
            end

            slas_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    out_addr_next      = res_addr_reg;
                    out_words_next     = res_words_reg;
                    out_channel_next   = res_channel_reg;
                    out_hold_next      = res_hold_reg;
                    out_resume_next    = res_resume_reg;
                    out_resume_ch_next = res_resume_ch_reg;
                    out_repeat_next    = res_repeat_reg;
                    out_frame_next     = res_frame_reg;
                    out_render_next    = res_render_reg;
                    state_next         = slas_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = slas_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= slas_pkg::ST_IDLE;
            active_lines_reg   <= slas_pkg::RESET_ACTIVE_LINES;
            active_pixels_reg  <= slas_pkg::RESET_ACTIVE_PIXELS;
            double_buffer_reg  <= 1'b1;
            base_zero_reg      <= '0;
            base_one_reg       <= '0;
            scanline_reg       <= DW'(slas_pkg::CHANNEL_COUNT);
            channel_index_reg  <= 1'b0;
            display_select_reg <= 1'b0;
            frame_pending_reg  <= 1'b0;
            change_pending_reg <= 1'b0;
            line_width_reg     <= slas_pkg::RESET_LINE_WIDTH;
            line_repeat_reg    <= slas_pkg::RESET_REPEAT;
            target_width_reg   <= slas_pkg::RESET_LINE_WIDTH;
            target_repeat_reg  <= slas_pkg::RESET_REPEAT;
            held_channel_reg   <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            active_lines_reg   <= active_lines_next;
            active_pixels_reg  <= active_pixels_next;
            double_buffer_reg  <= double_buffer_next;
            base_zero_reg      <= base_zero_next;
            base_one_reg       <= base_one_next;
            scanline_reg       <= scanline_next;
            channel_index_reg  <= channel_index_next;
            display_select_reg <= display_select_next;
            frame_pending_reg  <= frame_pending_next;
            change_pending_reg <= change_pending_next;
            line_width_reg     <= line_width_next;
            line_repeat_reg    <= line_repeat_next;
            target_width_reg   <= target_width_next;
            target_repeat_reg  <= target_repeat_next;
            held_channel_reg   <= held_channel_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        res_addr_reg      <= res_addr_next;
        res_words_reg     <= res_words_next;
        res_channel_reg   <= res_channel_next;
        res_hold_reg      <= res_hold_next;
        res_resume_reg    <= res_resume_next;
        res_resume_ch_reg <= res_resume_ch_next;
        res_repeat_reg    <= res_repeat_next;
        res_frame_reg     <= res_frame_next;
        res_render_reg    <= res_render_next;
        out_addr_reg      <= out_addr_next;
        out_words_reg     <= out_words_next;
        out_channel_reg   <= out_channel_next;
        out_hold_reg      <= out_hold_next;
        out_resume_reg    <= out_resume_next;
        out_resume_ch_reg <= out_resume_ch_next;
        out_repeat_reg    <= out_repeat_next;
        out_frame_reg     <= out_frame_next;
        out_render_reg    <= out_render_next;
    end

    assign in_stall       = (state_reg != slas_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign line_address   = out_addr_reg;
    assign word_count     = out_words_reg;
    assign channel        = out_channel_reg;
    assign hold_channel   = out_hold_reg;
    assign resume         = out_resume_reg;
    assign resume_channel = out_resume_ch_reg;
    assign pixel_repeat   = out_repeat_reg;
    assign frame_start    = out_frame_reg;
    assign render_request = out_render_reg;

endmodule

/* sim/tb_scanout_line_address_sequencer.sv */
// Self-checking testbench for the scanout line address sequencer: predictor, scoreboard and drivers.
module tb_scanout_line_address_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DIM_W       = slas_pkg::DIM_W;
    localparam int unsigned ADDR_W      = slas_pkg::ADDR_W;
    localparam int unsigned WORDS_W     = slas_pkg::WORDS_W;
    localparam int unsigned CFG_INDEX_W = slas_pkg::CFG_INDEX_W;
    localparam int unsigned CFG_DATA_W  = slas_pkg::CFG_DATA_W;

    // kind code with no meaning to the block; it must come back as an all-zero result
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // one line program as it leaves the block
    typedef struct packed {
        logic [ADDR_W-1:0]  line_address;
        logic [WORDS_W-1:0] word_count;
        logic               channel;
        logic               hold_channel;
        logic               resume;
        logic               resume_channel;
        logic [DIM_W-1:0]   pixel_repeat;
        logic               frame_start;
        logic               render_request;
    } line_program_t;

    // Tracks the sequencer state alongside the block and queues the line program that each
    // accepted event transfer should produce. Every event yields exactly one result transfer.
    class line_program_tracker;
        // register copies
        logic [DIM_W-1:0]  reg_active_lines;
        logic [DIM_W-1:0]  reg_active_pixels;
        logic              reg_double_buffer;
        logic [ADDR_W-1:0] reg_base_zero;
        logic [ADDR_W-1:0] reg_base_one;
        // sequencer state
        logic [DIM_W-1:0]  scanline;
        logic              chan_next;
        logic              shown_buffer;
        logic              frame_waiting;
        logic              mode_waiting;
        logic [DIM_W-1:0]  cur_width;
        logic [DIM_W-1:0]  cur_repeat;
        logic [DIM_W-1:0]  tgt_width;
        logic [DIM_W-1:0]  tgt_repeat;
        logic [1:0]        held_slot;     // 0 none, else channel + 1
        line_program_t     queued_programs[$];
        int                faults;
        int                programs_checked;
        int                frame_wraps;
        int                buffer_flips;
        int                holds_issued;
        int                resumes_issued;

        function new();
            reg_active_lines  = slas_pkg::RESET_ACTIVE_LINES;
            reg_active_pixels = slas_pkg::RESET_ACTIVE_PIXELS;
            reg_double_buffer = 1'b1;
            reg_base_zero     = '0;
            reg_base_one      = '0;
            scanline          = DIM_W'(slas_pkg::CHANNEL_COUNT);
            chan_next         = 1'b0;
            shown_buffer      = 1'b0;
            frame_waiting     = 1'b0;
            mode_waiting      = 1'b0;
            cur_width         = slas_pkg::RESET_LINE_WIDTH;
            cur_repeat        = slas_pkg::RESET_REPEAT;
            tgt_width         = slas_pkg::RESET_LINE_WIDTH;
            tgt_repeat        = slas_pkg::RESET_REPEAT;
            held_slot         = 2'd0;
            faults            = 0;
            programs_checked  = 0;
            frame_wraps       = 0;
            buffer_flips      = 0;
            holds_issued      = 0;
            resumes_issued    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                slas_pkg::CFG_ACTIVE_LINES:  reg_active_lines  = val[DIM_W-1:0];
                slas_pkg::CFG_ACTIVE_PIXELS: reg_active_pixels = val[DIM_W-1:0];
                slas_pkg::CFG_DOUBLE_BUFFER: reg_double_buffer = val[0];
                slas_pkg::CFG_BUFFER_ZERO:   reg_base_zero     = val;
                slas_pkg::CFG_BUFFER_ONE:    reg_base_one      = val;
                default: ;
            endcase
        endfunction

        // quotient with a zero divisor taken as one and a zero quotient raised to one
        function logic [DIM_W-1:0] ratio_min_one(logic [DIM_W-1:0] num, logic [DIM_W-1:0] den);
            logic [DIM_W-1:0] d;
            logic [DIM_W-1:0] q;
            d = (den == '0) ? DIM_W'(1) : den;
            q = num / d;
            return (q == '0) ? DIM_W'(1) : q;
        endfunction

        function void note_event(logic [1:0] k, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
            line_program_t     prog;
            logic              ch;
            logic [ADDR_W-1:0] base;
            logic [ADDR_W-1:0] row;
            prog = '0;
            if (k == slas_pkg::KIND_FRAME_READY)
            begin
                // a second frame_ready while one is pending changes nothing
                if (!frame_waiting)
                begin
                    if (tgt_width != cur_width || tgt_repeat != cur_repeat)
                        mode_waiting = 1'b1;
                    frame_waiting = 1'b1;
                end
            end
            else if (k == slas_pkg::KIND_MODE_REQUEST)
            begin
                frame_waiting = 1'b0;
                if (!reg_double_buffer)
                    shown_buffer = 1'b0;
                tgt_width  = w;
                tgt_repeat = ratio_min_one(reg_active_lines, h);
            end
            else if (k == slas_pkg::KIND_LINE_DONE)
            begin
                ch        = chan_next;
                chan_next = ~ch;    // two channels alternate
                if (scanline >= reg_active_lines)
                begin
                    scanline = '0;
                    prog.frame_start = 1'b1;
                    frame_wraps++;
                    if (frame_waiting)
                    begin
                        if (reg_double_buffer)
                        begin
                            shown_buffer = ~shown_buffer;
                            buffer_flips++;
                        end
                        frame_waiting = 1'b0;
                        prog.render_request = 1'b1;
                    end
                    if (mode_waiting)
                    begin
                        if (cur_width != tgt_width)
                        begin
                            held_slot = {1'b0, ch} + 2'd1;
                            prog.hold_channel = 1'b1;
                            holds_issued++;
                        end
                        cur_repeat   = tgt_repeat;
                        cur_width    = tgt_width;
                        mode_waiting = 1'b0;
                    end
                end
                else if (held_slot != 2'd0)
                begin
                    prog.resume         = 1'b1;
                    prog.resume_channel = 1'(held_slot - 2'd1);
                    prog.pixel_repeat   = ratio_min_one(reg_active_pixels, cur_width);
                    held_slot           = 2'd0;
                    resumes_issued++;
                end
                base = shown_buffer ? reg_base_one : reg_base_zero;
                row  = ADDR_W'(scanline) / ADDR_W'((cur_repeat == '0) ? DIM_W'(1) : cur_repeat);
                prog.line_address = base + 32'd2 * row * ADDR_W'(cur_width);
                prog.word_count   = WORDS_W'(cur_width >> 1);
                prog.channel      = ch;
                scanline          = scanline + DIM_W'(1);
            end
            queued_programs.push_back(prog);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                faults++;
            end
        endfunction

        function void check_program(line_program_t got);
            line_program_t want;
            if (queued_programs.size() == 0)
            begin
                $error("result transfer with no event waiting for it");
                faults++;
                return;
            end
            want = queued_programs.pop_front();
            programs_checked++;
            compare_field("line_address",   want.line_address,        got.line_address);
            compare_field("word_count",     32'(want.word_count),     32'(got.word_count));
            compare_field("channel",        32'(want.channel),        32'(got.channel));
            compare_field("hold_channel",   32'(want.hold_channel),   32'(got.hold_channel));
            compare_field("resume",         32'(want.resume),         32'(got.resume));
            compare_field("resume_channel", 32'(want.resume_channel), 32'(got.resume_channel));
            compare_field("pixel_repeat",   32'(want.pixel_repeat),   32'(got.pixel_repeat));
            compare_field("frame_start",    32'(want.frame_start),    32'(got.frame_start));
            compare_field("render_request", 32'(want.render_request), 32'(got.render_request));
        endfunction

        function int pending();
            return queued_programs.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals; every block input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             kind = slas_pkg::KIND_LINE_DONE;
    logic [DIM_W-1:0]       new_width = '0;
    logic [DIM_W-1:0]       new_height = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [ADDR_W-1:0]      line_address;
    logic [WORDS_W-1:0]     word_count;
    logic                   channel;
    logic                   hold_channel;
    logic                   resume;
    logic                   resume_channel;
    logic [DIM_W-1:0]       pixel_repeat;
    logic                   frame_start;
    logic                   render_request;

    // random idling on each side; cleared together for the no-idle stretch
    bit tx_idling = 1'b1;
    bit rx_idling = 1'b1;

    line_program_tracker tracker;

    scanout_line_address_sequencer DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .new_width      (new_width),
        .new_height     (new_height),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .line_address   (line_address),
        .word_count     (word_count),
        .channel        (channel),
        .hold_channel   (hold_channel),
        .resume         (resume),
        .resume_channel (resume_channel),
        .pixel_repeat   (pixel_repeat),
        .frame_start    (frame_start),
        .render_request (render_request)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side. Outputs are read at the edge (pre-edge values), and out_stall is
    // redrawn once per edge, so a stall can land on any cycle of the block's work.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_program(line_program_t'{line_address, word_count, channel,
                                                  hold_channel, resume, resume_channel,
                                                  pixel_repeat, frame_start,
                                                  render_request});
        out_stall <= rx_idling && ($urandom_range(99) < 18);
    end

    // Mostly in-range sizes, sometimes anything the 11-bit field holds (zero included).
    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(99) < 80)
            return DIM_W'($urandom_range(96, 1024));
        return DIM_W'($urandom_range(0, 2047));
    endfunction

    // Present one event and hold it until the transfer happens. Valid stays high between
    // back-to-back events; only the payload changes after an accepted transfer.
    task automatic send_event(input logic [1:0] k, input logic [DIM_W-1:0] w,
                              input logic [DIM_W-1:0] h);
        if (tx_idling && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        new_width  <= w;
        new_height <= h;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_event(k, w, h);
    endtask

    task automatic send_lines(input int count);
        repeat (count) send_event(slas_pkg::KIND_LINE_DONE, pick_dim(), pick_dim());
    endtask

    // Drop valid and wait for every queued line program to come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        tracker.write_reg(idx, val);
    endtask

    // Drain the block, then reprogram all registers.
    task automatic program_regs(input logic [DIM_W-1:0] lines, input logic [DIM_W-1:0] pixels,
                                input logic dbl, input logic [ADDR_W-1:0] base0,
                                input logic [ADDR_W-1:0] base1);
        drain();
        repeat (4) @(posedge clk);
        put_reg(slas_pkg::CFG_ACTIVE_LINES,  CFG_DATA_W'(lines));
        put_reg(slas_pkg::CFG_ACTIVE_PIXELS, CFG_DATA_W'(pixels));
        put_reg(slas_pkg::CFG_DOUBLE_BUFFER, CFG_DATA_W'(dbl));
        put_reg(slas_pkg::CFG_BUFFER_ZERO,   base0);
        put_reg(slas_pkg::CFG_BUFFER_ONE,    base1);
        cfg_we <= 1'b0;
    endtask

    // Random traffic. Most of it is mode_request / frame_ready followed by a random run of
    // lines, up to two past the frame height (capped at 32), so mode changes, holds and
    // resumes can happen; the rest is a bare run of lines or one loose event of any kind with arbitrary sizes.
    task automatic random_burst(input int count);
        int sent;
        int choice;
        int span;
        int n;
        int k;
        sent = 0;
        while (sent < count)
        begin
            choice = $urandom_range(99);
            span = (tracker.reg_active_lines > 30) ? 32 : int'(tracker.reg_active_lines) + 2;
            if (choice < 45)
            begin
                send_event(slas_pkg::KIND_MODE_REQUEST, pick_dim(), pick_dim());
                send_event(slas_pkg::KIND_FRAME_READY, pick_dim(), pick_dim());
                sent += 2;
            end
            else if (choice < 70)
            begin
                send_event(slas_pkg::KIND_FRAME_READY, pick_dim(), pick_dim());
                sent++;
            end
            if (choice < 80)
            begin
                n = $urandom_range(1, span);
                send_lines(n);
                sent += n;
            end
            else
            begin
                k = $urandom_range(0, 3);
                send_event(2'(k), DIM_W'($urandom_range(0, 2047)), DIM_W'($urandom_range(0, 2047)));
                if (2'(k) != KIND_UNKNOWN)
                    sent++;
            end
        end
    endtask

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        tracker = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset registers: plain lines, the all-ones payload, an unknown kind,
        // frame_ready twice (second one ignored) and a mode request.
        send_event(slas_pkg::KIND_LINE_DONE, '0, '0);
        send_event(slas_pkg::KIND_LINE_DONE, '1, '1);
        send_event(KIND_UNKNOWN, '1, '1);
        send_event(slas_pkg::KIND_FRAME_READY, '0, '0);
        send_event(slas_pkg::KIND_FRAME_READY, '1, '1);
        send_event(slas_pkg::KIND_MODE_REQUEST, DIM_W'(1024), DIM_W'(96));

        // Frame shorter than the current scanline, so the next line wraps at once; base zero
        // near the top of the address space.
        program_regs(DIM_W'(3), DIM_W'(1024), 1'b1, 32'hFFFF_FF00, 32'h1000_0000);
        send_event(slas_pkg::KIND_FRAME_READY, '0, '0);
        send_lines(2);                                   // wrap with hold, then resume
        send_event(slas_pkg::KIND_MODE_REQUEST, '0, '0); // zero width, zero height
        send_event(slas_pkg::KIND_FRAME_READY, '0, '0);
        send_lines(4);                                   // resume with pixel repeat from width 0
        send_event(slas_pkg::KIND_MODE_REQUEST, '1, '1); // repeat quotient of zero
        send_event(slas_pkg::KIND_FRAME_READY, '0, '0);
        send_lines(4);

        // Random phases over several register settings, extremes included.
        program_regs(DIM_W'(1), DIM_W'(1), 1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        random_burst(90);

        // long stretch with no idling on either side
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        program_regs(DIM_W'($urandom_range(2, 12)), DIM_W'(1024), 1'b1, $urandom, $urandom);
        random_burst(160);
        tx_idling = 1'b1;
        rx_idling = 1'b1;

        program_regs(DIM_W'(1024), DIM_W'($urandom_range(1, 1024)), 1'b1, 32'hFFFF_FFFF,
                     32'h0000_0000);
        random_burst(80);

        program_regs(DIM_W'($urandom_range(3, 24)), DIM_W'($urandom_range(0, 2047)),
                     1'($urandom_range(0, 1)), $urandom, $urandom);
        random_burst(75);
        drain();                                         // sender holds off until all is back
        random_burst(75);

        // single buffering after the shown buffer may have flipped to one
        program_regs(DIM_W'($urandom_range(1, 8)), DIM_W'(640), 1'b0, $urandom, $urandom);
        random_burst(120);

        program_regs(DIM_W'($urandom_range(8, 40)), DIM_W'($urandom_range(512, 2047)), 1'b1,
                     $urandom, $urandom);
        random_burst(100);

        drain();
        repeat (40) @(posedge clk);

        $display("Checked %0d line programs across 8 register settings: %0d frame wraps,",
                 tracker.programs_checked, tracker.frame_wraps);
        $display("%0d buffer flips, %0d channel holds, %0d resumes, %0d mismatches.",
                 tracker.buffer_flips, tracker.holds_issued, tracker.resumes_issued,
                 tracker.faults);
        if (tracker.faults == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
